// File: design/cfb_pkg.sv
// Shared types and constants for the change-tracking feedback table.
// Used by every module of the block except cfb_ram; depends on nothing.
package cfb_pkg;

    localparam int SLOTS      = 128;
    localparam int SLOT_W     = 7;
    localparam int MAX_SENDS  = 16;
    localparam int CNT_W      = 5;
    localparam int TOL_W      = 31;
    localparam int CFG_W      = 31;

    localparam logic CFG_SINK_READY = 1'b0;
    localparam logic CFG_ECHO_TOL   = 1'b1;

    localparam logic [2:0] FN_PUBLISH  = 3'd0;
    localparam logic [2:0] FN_RETIRE   = 3'd1;
    localparam logic [2:0] FN_RECEIVED = 3'd2;
    localparam logic [2:0] FN_SNAPSHOT = 3'd3;
    localparam logic [2:0] FN_CLEAR    = 3'd4;
    localparam logic [2:0] FN_FLUSH    = 3'd5;

    localparam logic KIND_VALUE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        OP_PUBLISH,
        OP_RETIRE,
        OP_RECEIVED,
        OP_SNAPSHOT,
        OP_CLEAR,
        OP_FLUSH
    } t_op;

    typedef struct packed {
        logic [2:0]        func;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       value;
        logic              slot_is_delta;
    } t_in_item;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] out_slot;
        logic [31:0]       out_value;
        logic [CNT_W-1:0]  sent_in_flush;
        logic [31:0]       deferred_total;
        logic [47:0]       sent_total;
        logic              last;
    } t_out_item;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       value;
        logic              delta;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_q;

endpackage

// File: design/cfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module cfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/cfb_front.sv
// Front end: accepts input beats, classifies them into commands and holds them
// in a two-entry queue for the back end. Depends on cfb_pkg.
module cfb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  cfb_pkg::t_in_item i_data,
    output logic              o_stall,
    input  logic              i_pop,
    output cfb_pkg::t_cmd_q   o_head
);
    cfb_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          known;
    logic          in_range;
    logic          push;
    logic          do_pop;
    cfb_pkg::t_cmd cmd;

    always_comb begin
        in_range  = int'(i_data.slot) < cfb_pkg::SLOTS;
        known     = 1'b1;
        cmd.slot  = i_data.slot;
        cmd.value = i_data.value;
        cmd.delta = i_data.slot_is_delta;
        cmd.op    = cfb_pkg::OP_FLUSH;
        unique case (i_data.func)
            cfb_pkg::FN_PUBLISH:  begin cmd.op = cfb_pkg::OP_PUBLISH;  known = in_range; end
            cfb_pkg::FN_RETIRE:   begin cmd.op = cfb_pkg::OP_RETIRE;   known = in_range; end
            cfb_pkg::FN_RECEIVED: begin cmd.op = cfb_pkg::OP_RECEIVED; known = in_range; end
            cfb_pkg::FN_SNAPSHOT: cmd.op = cfb_pkg::OP_SNAPSHOT;
            cfb_pkg::FN_CLEAR:    cmd.op = cfb_pkg::OP_CLEAR;
            cfb_pkg::FN_FLUSH:    cmd.op = cfb_pkg::OP_FLUSH;
            default:              known = 1'b0;
        endcase
    end

    assign o_stall      = (r_cnt == 2'd2);
    assign push         = i_valid && !o_stall && known;
    assign do_pop       = i_pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(do_pop);
        end
    end
endmodule

// File: design/cfb_back.sv
// Back end: executes queued commands against the mark bitmaps and value RAMs,
// walks the table on a flush and drives the registered result beat.
// Depends on cfb_pkg and cfb_ram.
module cfb_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  cfb_pkg::t_cmd_q         i_head,
    output logic                    o_pop,
    input  logic                    i_sink_ready,
    input  logic [cfb_pkg::TOL_W-1:0] i_echo_tol,
    output logic                    o_out_valid,
    output cfb_pkg::t_out_item      o_out_data,
    input  logic                    i_out_stall
);
    typedef enum logic [2:0] {S_IDLE, S_PUB, S_SCAN, S_CHECK, S_SUM} t_state;

    localparam int SW = cfb_pkg::SLOT_W;
    localparam int CW = cfb_pkg::CNT_W;

    t_state                   r_state;
    cfb_pkg::t_cmd            r_cmd;
    logic [cfb_pkg::SLOTS-1:0] r_valid, r_has_sent, r_dirty, r_echo, r_delta;
    logic                     r_snap;
    logic                     r_snap_act;
    logic [31:0]              r_defer;
    logic [47:0]              r_total;
    logic [cfb_pkg::CNT_W-1:0] r_cnt;
    logic [SW-1:0]            r_idx;
    logic                     r_out_valid;
    cfb_pkg::t_out_item       r_out;

    logic [31:0] cur_rd, ls_rd, rcv_rd;
    logic        cur_we, ls_we, rcv_we;
    logic        out_free;
    logic        at_end;
    logic signed [32:0] diff;
    logic [32:0] mag;
    logic        echo_ok;
    logic        sending;
    logic [47:0] n_total;

    assign out_free = !r_out_valid;
    assign at_end   = (r_idx == SW'(cfb_pkg::SLOTS - 1));
    assign o_pop    = (r_state == S_IDLE) && i_head.valid;

    assign diff    = 33'($signed(cur_rd)) - 33'($signed(rcv_rd));
    assign mag     = diff[32] ? 33'(-diff) : 33'(diff);
    assign echo_ok = !r_snap_act && r_echo[r_idx] && (mag <= {2'b00, i_echo_tol});
    assign sending = !echo_ok && (int'(r_cnt) < cfb_pkg::MAX_SENDS) && i_sink_ready;
    assign n_total = r_total + 48'(r_cnt);

    assign cur_we = (r_state == S_PUB);
    assign rcv_we = o_pop && (i_head.cmd.op == cfb_pkg::OP_RECEIVED);
    assign ls_we  = (r_state == S_CHECK) && (echo_ok || (sending && out_free));

    cfb_ram #(.WIDTH(32), .DEPTH(cfb_pkg::SLOTS)) u_cur (
        .i_clk(i_clk), .i_we(cur_we), .i_waddr(r_cmd.slot), .i_wdata(r_cmd.value),
        .i_raddr(r_idx), .o_rdata(cur_rd)
    );
    cfb_ram #(.WIDTH(32), .DEPTH(cfb_pkg::SLOTS)) u_last_sent (
        .i_clk(i_clk), .i_we(ls_we), .i_waddr(r_idx), .i_wdata(cur_rd),
        .i_raddr(i_head.cmd.slot), .o_rdata(ls_rd)
    );
    cfb_ram #(.WIDTH(32), .DEPTH(cfb_pkg::SLOTS)) u_received (
        .i_clk(i_clk), .i_we(rcv_we), .i_waddr(i_head.cmd.slot),
        .i_wdata(i_head.cmd.value), .i_raddr(r_idx), .o_rdata(rcv_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_has_sent  <= '0;
            r_dirty     <= '0;
            r_echo      <= '0;
            r_delta     <= '0;
            r_snap      <= 1'b0;
            r_snap_act  <= 1'b0;
            r_defer     <= '0;
            r_total     <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_cmd <= i_head.cmd;
                        unique case (i_head.cmd.op)
                            cfb_pkg::OP_PUBLISH: r_state <= S_PUB;
                            cfb_pkg::OP_RETIRE: begin
                                r_valid[i_head.cmd.slot]    <= 1'b0;
                                r_dirty[i_head.cmd.slot]    <= 1'b0;
                                r_has_sent[i_head.cmd.slot] <= 1'b0;
                            end
                            cfb_pkg::OP_RECEIVED: r_echo[i_head.cmd.slot] <= 1'b1;
                            cfb_pkg::OP_SNAPSHOT: r_snap <= 1'b1;
                            cfb_pkg::OP_CLEAR: begin
                                r_valid    <= '0;
                                r_has_sent <= '0;
                                r_dirty    <= '0;
                                r_echo     <= '0;
                                r_snap     <= 1'b0;
                            end
                            cfb_pkg::OP_FLUSH: begin
                                r_snap_act <= r_snap;
                                r_snap     <= 1'b0;
                                if (r_snap) begin
                                    r_dirty <= r_dirty | r_valid;
                                end
                                r_idx   <= '0;
                                r_cnt   <= '0;
                                r_state <= S_SCAN;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_PUB: begin
                    // The last-sent entry was read when the command was popped.
                    r_valid[r_cmd.slot] <= 1'b1;
                    r_delta[r_cmd.slot] <= r_cmd.delta;
                    r_dirty[r_cmd.slot] <= !r_has_sent[r_cmd.slot] || (ls_rd != r_cmd.value);
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    if (r_dirty[r_idx] && !r_delta[r_idx]) begin
                        r_state <= S_CHECK;
                    end else begin
                        if (r_dirty[r_idx]) begin
                            r_dirty[r_idx] <= 1'b0;
                        end
                        if (at_end) begin
                            r_state <= S_SUM;
                        end else begin
                            r_idx <= r_idx + SW'(1);
                        end
                    end
                end
                S_CHECK: begin
                    if (sending && !out_free) begin
                        r_state <= S_CHECK;
                    end else begin
                        if (echo_ok) begin
                            r_has_sent[r_idx] <= 1'b1;
                            r_dirty[r_idx]    <= 1'b0;
                        end else if (int'(r_cnt) >= cfb_pkg::MAX_SENDS) begin
                            r_defer <= r_defer + 32'd1;
                        end else if (sending) begin
                            r_has_sent[r_idx] <= 1'b1;
                            r_dirty[r_idx]    <= 1'b0;
                            r_cnt             <= r_cnt + CW'(1);
                            r_out_valid       <= 1'b1;
                            r_out <= '{kind: cfb_pkg::KIND_VALUE, out_slot: r_idx,
                                       out_value: cur_rd, sent_in_flush: '0,
                                       deferred_total: '0, sent_total: '0, last: 1'b0};
                        end
                        if (at_end) begin
                            r_state <= S_SUM;
                        end else begin
                            r_idx   <= r_idx + SW'(1);
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SUM: begin
                    if (out_free) begin
                        r_echo      <= '0;
                        r_total     <= n_total;
                        r_out_valid <= 1'b1;
                        r_out <= '{kind: cfb_pkg::KIND_SUMMARY, out_slot: '0, out_value: '0,
                                   sent_in_flush: r_cnt, deferred_total: r_defer,
                                   sent_total: n_total, last: 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

// File: design/change_tracking_feedback_table.sv
// Top level of the change-tracking feedback table: configuration registers,
// front-end command queue and back-end executor. Depends on cfb_pkg,
// cfb_front and cfb_back.
//
// Retire, note-received, snapshot and reset-marks commands finish in the idle
// state of the back end; publish also passes through S_PUB, as it reads the
// last-sent RAM before it can decide the dirty mark. A flush walks all 128
// slots in S_SCAN, one per cycle, plus S_CHECK for each dirty non-delta slot
// for the value RAM reads, then S_SUM for the summary; S_CHECK and S_SUM wait
// while the result beat is stalled. The two-entry command queue keeps
// accepting beats while the back end is busy, until both entries are full.
module change_tracking_feedback_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  cfb_pkg::t_in_item          i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output cfb_pkg::t_out_item         o_out_data,
    input  logic                       i_out_stall,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [cfb_pkg::CFG_W-1:0]  i_cfg_data
);
    logic                        r_sink_ready;
    logic [cfb_pkg::TOL_W-1:0]   r_echo_tol;
    cfb_pkg::t_cmd_q             head;
    logic                        pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sink_ready <= 1'b1;
            r_echo_tol   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cfb_pkg::CFG_SINK_READY: r_sink_ready <= i_cfg_data[0];
                cfb_pkg::CFG_ECHO_TOL:   r_echo_tol   <= i_cfg_data[cfb_pkg::TOL_W-1:0];
                default:                 r_sink_ready <= r_sink_ready;
            endcase
        end
    end

    cfb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_in_valid), .i_data(i_in_data),
        .o_stall(o_in_stall), .i_pop(pop), .o_head(head)
    );

    cfb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_head(head), .o_pop(pop),
        .i_sink_ready(r_sink_ready), .i_echo_tol(r_echo_tol),
        .o_out_valid(o_out_valid), .o_out_data(o_out_data), .i_out_stall(i_out_stall)
    );

    a_summary_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == cfb_pkg::KIND_SUMMARY)
            |-> (int'(o_out_data.sent_in_flush) <= cfb_pkg::MAX_SENDS))
        else $error("flush summary exceeds send budget");

    a_value_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.kind == cfb_pkg::KIND_VALUE)
            |-> (!o_out_data.last && o_out_data.sent_in_flush == '0))
        else $error("value beat carries summary fields");

    a_no_result_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && head.cmd.op != cfb_pkg::OP_FLUSH) |=> !$rose(o_out_valid))
        else $error("non-flush command produced a result");
endmodule

// File: dv/cfb_checker.sv
`timescale 1ns / 1ps
// Checker for the change-tracking feedback table: mirrors the slot table,
// predicts every result beat of a flush and compares it. Depends on cfb_pkg.
module cfb_checker
    import cfb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  t_in_item         i_in_data,
    input  logic             i_in_stall,
    input  logic             i_out_valid,
    input  t_out_item        i_out_data,
    input  logic             i_out_stall,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_flush_count
);

    logic [31:0]       cur_val [SLOTS];
    logic [31:0]       sent_val [SLOTS];
    logic [31:0]       rcv_val [SLOTS];
    logic [SLOTS-1:0]  valid_m, sent_m, dirty_m, echo_m, delta_m;
    logic              snap_req;
    logic [31:0]       defer_cnt;
    logic [47:0]       sent_cnt;
    logic              sink_ok;
    logic [TOL_W-1:0]  echo_tol;
    t_out_item         beat_queue [$];

    function automatic t_out_item make_beat(logic kind, logic [6:0] s, logic [31:0] v,
                                            logic [4:0] n, logic [31:0] d,
                                            logic [47:0] t, logic lst);
        t_out_item r;
        r.kind = kind; r.out_slot = s; r.out_value = v; r.sent_in_flush = n;
        r.deferred_total = d; r.sent_total = t; r.last = lst;
        return r;
    endfunction

    task automatic run_flush();
        logic snap;
        int sent;
        longint diff;
        snap = snap_req;
        sent = 0;
        snap_req = 1'b0;
        if (snap) dirty_m |= valid_m;
        for (int i = 0; i < SLOTS; i++) begin
            if (!dirty_m[i]) continue;
            if (delta_m[i]) begin
                dirty_m[i] = 1'b0;
                continue;
            end
            if (!snap && echo_m[i]) begin
                diff = longint'($signed(cur_val[i])) - longint'($signed(rcv_val[i]));
                if (diff < 0) diff = -diff;
                if (diff <= longint'(echo_tol)) begin
                    sent_val[i] = cur_val[i];
                    sent_m[i] = 1'b1;
                    dirty_m[i] = 1'b0;
                    continue;
                end
            end
            if (sent >= MAX_SENDS) begin
                defer_cnt = defer_cnt + 32'd1;
                continue;
            end
            if (!sink_ok) continue;
            beat_queue.push_back(make_beat(KIND_VALUE, i[6:0], cur_val[i], '0, '0, '0,
                                           1'b0));
            sent_val[i] = cur_val[i];
            sent_m[i] = 1'b1;
            dirty_m[i] = 1'b0;
            sent++;
        end
        echo_m = '0;
        sent_cnt = sent_cnt + 48'(sent);
        beat_queue.push_back(make_beat(KIND_SUMMARY, '0, '0, sent[4:0], defer_cnt,
                                       sent_cnt, 1'b1));
    endtask

    task automatic apply_item(t_in_item it);
        case (it.func)
            FN_PUBLISH: begin
                cur_val[it.slot] = it.value;
                valid_m[it.slot] = 1'b1;
                delta_m[it.slot] = it.slot_is_delta;
                dirty_m[it.slot] = !sent_m[it.slot] || sent_val[it.slot] != it.value;
            end
            FN_RETIRE: begin
                valid_m[it.slot] = 1'b0;
                dirty_m[it.slot] = 1'b0;
                sent_m[it.slot] = 1'b0;
            end
            FN_RECEIVED: begin
                rcv_val[it.slot] = it.value;
                echo_m[it.slot] = 1'b1;
            end
            FN_SNAPSHOT: snap_req = 1'b1;
            FN_CLEAR: begin
                valid_m = '0; sent_m = '0; dirty_m = '0; echo_m = '0;
                snap_req = 1'b0;
            end
            FN_FLUSH: run_flush();
            default: ;
        endcase
    endtask

    task automatic check_beat(t_out_item got);
        t_out_item want;
        if (beat_queue.size() == 0) begin
            $error("result beat with nothing expected: %p", got);
            o_fail_count++;
            return;
        end
        want = beat_queue.pop_front();
        if (got.kind != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind); o_fail_count++;
        end
        if (got.out_slot != want.out_slot) begin
            $error("out_slot: expected %0d, got %0d", want.out_slot, got.out_slot);
            o_fail_count++;
        end
        if (got.out_value != want.out_value) begin
            $error("out_value: expected %h, got %h", want.out_value, got.out_value);
            o_fail_count++;
        end
        if (got.sent_in_flush != want.sent_in_flush) begin
            $error("sent_in_flush: expected %0d, got %0d", want.sent_in_flush,
                   got.sent_in_flush);
            o_fail_count++;
        end
        if (got.deferred_total != want.deferred_total) begin
            $error("deferred_total: expected %0d, got %0d", want.deferred_total,
                   got.deferred_total);
            o_fail_count++;
        end
        if (got.sent_total != want.sent_total) begin
            $error("sent_total: expected %0d, got %0d", want.sent_total, got.sent_total);
            o_fail_count++;
        end
        if (got.last != want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last); o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_flush_count = 0;
        o_pending = 0;
    end

    // Value arrays start at zero; the guarding marks keep them from being read unwritten.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                cur_val[i] = '0; sent_val[i] = '0; rcv_val[i] = '0;
            end
            valid_m = '0; sent_m = '0; dirty_m = '0; echo_m = '0; delta_m = '0;
            snap_req = 1'b0; defer_cnt = '0; sent_cnt = '0;
            sink_ok = 1'b1; echo_tol = '0;
            beat_queue.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_beat(i_out_data);
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SINK_READY) sink_ok = i_cfg_data[0];
                else echo_tol = i_cfg_data[TOL_W-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.func == FN_FLUSH) o_flush_count++;
                apply_item(i_in_data);
            end
        end
        o_pending = beat_queue.size();
    end

endmodule

// File: dv/tb_change_tracking_feedback_table.sv
`timescale 1ns / 1ps
// Testbench top for the change-tracking feedback table: clock, reset,
// stimulus and verdict. Depends on cfb_pkg and cfb_checker.
module tb_change_tracking_feedback_table;
    import cfb_pkg::*;

    logic             clk, rst_n;
    logic             in_valid, in_stall, out_valid, out_stall;
    t_in_item         in_data;
    t_out_item        out_data;
    logic             cfg_we, cfg_idx;
    logic [CFG_W-1:0] cfg_data;
    int               fail_count, pending, flush_count;
    int               hold_off;
    logic [6:0]       hot_slots [8];

    change_tracking_feedback_table dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_data(in_data),
        .o_in_stall(in_stall), .o_out_valid(out_valid), .o_out_data(out_data),
        .i_out_stall(out_stall), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data)
    );

    cfb_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_data(in_data),
        .i_in_stall(in_stall), .i_out_valid(out_valid), .i_out_data(out_data),
        .i_out_stall(out_stall), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .o_fail_count(fail_count), .o_pending(pending),
        .o_flush_count(flush_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        int n;
        out_stall = 1'b0;
        hold_off = 0;
        forever begin
            @(posedge clk);
            if (hold_off > 0) begin
                out_stall <= 1'b1;
                hold_off--;
            end else begin
                n = gap_len();
                if (n == 0) out_stall <= 1'b0;
                else begin
                    out_stall <= 1'b1;
                    repeat (n - 1) @(posedge clk);
                    @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic send_beat(t_in_item it, bit gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_op(logic [2:0] f, logic [6:0] s, logic [31:0] v, logic dl);
        t_in_item it;
        it.func = f; it.slot = s; it.value = v; it.slot_is_delta = dl;
        send_beat(it, 1'b1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] d);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_item();
        t_in_item it;
        int r;
        r = $urandom_range(0, 99);
        it.slot = ($urandom_range(0, 3) == 0) ? 7'($urandom) : hot_slots[$urandom_range(0, 7)];
        it.value = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 6)) : $urandom;
        it.slot_is_delta = ($urandom_range(0, 5) == 0);
        if (r < 40) it.func = FN_PUBLISH;
        else if (r < 48) it.func = FN_RETIRE;
        else if (r < 66) it.func = FN_RECEIVED;
        else if (r < 72) it.func = FN_SNAPSHOT;
        else if (r < 75) it.func = FN_CLEAR;
        else if (r < 96) it.func = FN_FLUSH;
        else it.func = 3'($urandom_range(6, 7));
        send_beat(it, 1'b1);
    endtask

    initial begin
        in_valid = 1'b0; in_data = '0;
        cfg_we = 1'b0; cfg_idx = CFG_SINK_READY; cfg_data = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (hot_slots[i]) hot_slots[i] = 7'($urandom);
        hot_slots[0] = 7'd0;
        hot_slots[1] = 7'd127;

        // Directed: field extremes, echoes, deltas, retire, clear, odd codes.
        write_reg(CFG_SINK_READY, 31'd1);
        write_reg(CFG_ECHO_TOL, 31'd0);
        send_op(FN_PUBLISH, 7'd0, 32'h8000_0000, 1'b0);
        send_op(FN_PUBLISH, 7'd127, 32'h7FFF_FFFF, 1'b0);
        send_op(FN_PUBLISH, 7'd5, 32'h0001_0000, 1'b1);
        send_op(FN_PUBLISH, 7'd6, 32'hFFFF_FFFF, 1'b0);
        send_op(FN_RECEIVED, 7'd6, 32'hFFFF_FFFF, 1'b0);
        send_op(FN_FLUSH, 7'd0, 0, 1'b0);
        send_op(FN_PUBLISH, 7'd0, 32'h8000_0000, 1'b0);
        send_op(FN_PUBLISH, 7'd127, 32'h7FFF_FFFE, 1'b0);
        send_op(FN_RETIRE, 7'd0, 0, 1'b0);
        send_op(FN_FLUSH, 7'd0, 0, 1'b0);
        send_op(FN_SNAPSHOT, 7'd0, 0, 1'b0);
        send_op(FN_RECEIVED, 7'd127, 32'h7FFF_FFFE, 1'b0);
        send_op(FN_FLUSH, 7'd0, 0, 1'b0);
        send_op(3'd6, 7'd1, 32'h1234, 1'b1);
        send_op(3'd7, 7'd2, 32'h5678, 1'b0);
        send_op(FN_SNAPSHOT, 7'd0, 0, 1'b0);
        send_op(FN_CLEAR, 7'd0, 0, 1'b0);
        send_op(FN_FLUSH, 7'd0, 0, 1'b0);
        drain();

        // Budget overflow with a huge tolerance, then a failing sink.
        write_reg(CFG_ECHO_TOL, 31'h7FFF_FFFF);
        for (int i = 0; i < 20; i++) send_op(FN_PUBLISH, 7'(i * 6), $urandom, 1'b0);
        send_op(FN_RECEIVED, 7'd6, 32'h8000_0000, 1'b0);
        send_op(FN_FLUSH, 7'd0, 0, 1'b0);
        send_op(FN_FLUSH, 7'd0, 0, 1'b0);
        drain();
        write_reg(CFG_SINK_READY, 31'd0);
        send_op(FN_PUBLISH, 7'd3, 32'h0000_0042, 1'b0);
        send_op(FN_FLUSH, 7'd0, 0, 1'b0);
        drain();

        // Random phases under several register settings.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_SINK_READY, (ph == 3) ? 31'd0 : 31'd1);
            write_reg(CFG_ECHO_TOL, (ph == 1) ? 31'h7FFF_FFFF :
                                    (ph == 2) ? 31'($urandom_range(0, 8)) : 31'($urandom));
            if (ph == 4) begin
                // Long receiver hold-off while flushes keep coming.
                hold_off = 800;
                for (int i = 0; i < 6; i++) send_op(FN_FLUSH, 7'd0, 0, 1'b0);
            end
            for (int i = 0; i < 50; i++) random_item();
            drain();
        end

        $display("Covered %0d flushes over directed and random phases,", flush_count);
        $display("including budget overflow, echo suppression and a failing sink.");
        if (fail_count == 0) $display("tb_change_tracking_feedback_table: PASS");
        else $display("tb_change_tracking_feedback_table: FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_change_tracking_feedback_table: FAIL");
        $finish;
    end

endmodule
